FILE: rtl/fsvwt_pkg.sv
package fsvwt_pkg;

  localparam int unsigned FifoBlocks = 44;
  localparam int unsigned BlockBytes = 1024;

  localparam int unsigned TickW   = 20;
  localparam int unsigned FieldW  = 8;
  localparam int unsigned TimeW   = 17;
  localparam int unsigned BlockW  = 6;
  localparam int unsigned AddrW   = 16;
  localparam int unsigned PaddrW  = 5;
  localparam int unsigned PdataW  = 32;

  localparam logic [TimeW-1:0] SecondsPerDay = TimeW'(86400);

  localparam logic [TickW-1:0]  VbiTicksReset     = TickW'(16650);
  localparam logic [TickW-1:0]  AccessTicksReset  = TickW'(544064);
  localparam logic [TickW-1:0]  PrepareTicksReset = TickW'(32064);
  localparam logic [FieldW-1:0] FieldsReset       = FieldW'(50);
  localparam logic [TimeW-1:0]  StartTimeReset    = TimeW'(36000);

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_FIELD  = 2'd1,
    MODE_ACK    = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    HOLD_NONE     = 2'd0,
    HOLD_ADVANCED = 2'd1,
    HOLD_PARITY   = 2'd2,
    HOLD_EMPTY    = 2'd3
  } hold_e;

  typedef enum logic [2:0] {
    REG_VBI_TICKS     = 3'd0,
    REG_ACCESS_TICKS  = 3'd1,
    REG_PREPARE_TICKS = 3'd2,
    REG_FIELDS        = 3'd3,
    REG_START_TIME    = 3'd4
  } reg_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic              field_level;
    logic [BlockW-1:0] write_block;
  } in_item_t;

  typedef struct packed {
    logic              vbi_done;
    logic              overrun;
    logic              window_busy;
    logic [BlockW-1:0] read_block;
    logic [AddrW-1:0]  read_address;
    logic              address_load;
    logic              mux_to_encoder;
    logic [TimeW-1:0]  time_of_day;
    logic              second_pulse;
    logic [1:0]        hold_reason;
  } out_item_t;

endpackage

FILE: rtl/field_synced_vbi_window_timer.sv
// Field-synchronized VBI window timer.
//
// Input channel: one transfer per event (base clock tick, field edge, or a
// software acknowledge of vbi_done), carrying the field pin level and the
// producer's write block. Output channel: exactly one result transfer per
// input transfer, in order, holding the flags, read block, latched read
// address, encoder select, time of day and the per-event strobes.
//
// All state updates for an event happen at the edge that accepts its input transfer, and the
// result is registered at that same edge. One transfer is accepted every cycle
// unless in_stall_o is raised (one 20-bit increment and compare per timer).
//
// The output side has a result register and a skid register. A stalled
// result holds on the port while one more transfer is still taken into the
// skid register; only when both are full is in_stall_o raised.
//
// Reset clears all timers and flags, loads the time of day with the start
// time (36000 s) and restores the register defaults. Configuration is written
// through the APB port at byte address 4*index; writing the start time also
// reloads the time of day.
module field_synced_vbi_window_timer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  fsvwt_pkg::in_item_t                 in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output fsvwt_pkg::out_item_t                out_item_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fsvwt_pkg::PaddrW-1:0]        paddr,
  input  logic [fsvwt_pkg::PdataW-1:0]        pwdata,
  output logic [fsvwt_pkg::PdataW-1:0]        prdata,
  output logic                                pready
);
  import fsvwt_pkg::*;

  // Configuration registers.
  logic [TickW-1:0]  vbi_ticks_q, access_ticks_q, prepare_ticks_q;
  logic [FieldW-1:0] fields_q;
  logic [TimeW-1:0]  start_time_q;

  // Block state.
  logic [FieldW-1:0] field_cnt_q, field_cnt_d;
  logic [TimeW-1:0]  seconds_q, seconds_d;
  logic              vbi_run_q, vbi_run_d;
  logic [TickW-1:0]  vbi_elapsed_q, vbi_elapsed_d;
  logic              acc_run_q, acc_run_d;
  logic [TickW-1:0]  acc_elapsed_q, acc_elapsed_d;
  logic              acc_prep_q, acc_prep_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              overrun_q, overrun_d;
  logic [BlockW-1:0] tx_block_q, tx_block_d;
  logic              enc_sel_q, enc_sel_d;
  logic [AddrW-1:0]  addr_q, addr_d;

  // Output buffering.
  logic      out_valid_q, skid_valid_q;
  out_item_t out_q, skid_q, result;

  logic              accept, cfg_write;
  reg_e              cfg_reg;
  logic [TickW-1:0]  acc_limit;
  logic [FieldW:0]   field_next, field_limit;
  logic [TimeW-1:0]  seconds_inc;
  logic [BlockW-1:0] next_block;
  logic              load, pulse;
  hold_e             hold;

  assign accept     = in_valid_i && !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_reg   = reg_e'(paddr[PaddrW-1:2]);

  always_comb begin
    case (cfg_reg)
      REG_VBI_TICKS:     prdata = PdataW'(vbi_ticks_q);
      REG_ACCESS_TICKS:  prdata = PdataW'(access_ticks_q);
      REG_PREPARE_TICKS: prdata = PdataW'(prepare_ticks_q);
      REG_FIELDS:        prdata = PdataW'(fields_q);
      REG_START_TIME:    prdata = PdataW'(start_time_q);
      default:           prdata = '0;
    endcase
  end

  // Helper values for the field edge and handover.
  assign field_next  = {1'b0, field_cnt_q} + 1'b1;
  assign field_limit = (fields_q == '0) ? {1'b1, {FieldW{1'b0}}} : {1'b0, fields_q};
  assign seconds_inc = seconds_q + 1'b1;
  assign next_block  = (tx_block_q == BlockW'(FifoBlocks - 1)) ? '0 : tx_block_q + 1'b1;
  assign acc_limit   = acc_prep_q ? prepare_ticks_q : access_ticks_q;

  always_comb begin
    field_cnt_d   = field_cnt_q;
    seconds_d     = seconds_q;
    vbi_run_d     = vbi_run_q;
    vbi_elapsed_d = vbi_elapsed_q;
    acc_run_d     = acc_run_q;
    acc_elapsed_d = acc_elapsed_q;
    acc_prep_d    = acc_prep_q;
    busy_d        = busy_q;
    done_d        = done_q;
    overrun_d     = overrun_q;
    tx_block_d    = tx_block_q;
    enc_sel_d     = enc_sel_q;
    addr_d        = addr_q;
    load          = 1'b0;
    pulse         = 1'b0;
    hold          = HOLD_NONE;

    case (mode_e'(in_item_i.mode))
      MODE_TICK: begin
        // The VBI timer is handled first; its end clears busy before the
        // access timer looks at it.
        if (vbi_run_q) begin
          vbi_elapsed_d = vbi_elapsed_q + 1'b1;
          if (vbi_elapsed_d >= vbi_ticks_q) begin
            vbi_run_d = 1'b0;
            overrun_d = done_q;
            done_d    = 1'b1;
            busy_d    = 1'b0;
          end
        end
        if (acc_run_q) begin
          acc_elapsed_d = acc_elapsed_q + 1'b1;
          if (acc_elapsed_d >= acc_limit) begin
            if (busy_d) begin
              acc_run_d = 1'b0;
              addr_d    = AddrW'(32'(tx_block_q) * BlockBytes);
              load      = 1'b1;
              enc_sel_d = 1'b1;
              if (next_block[0] == in_item_i.field_level) begin
                hold = HOLD_PARITY;
              end else if (next_block == in_item_i.write_block) begin
                hold = HOLD_EMPTY;
              end else begin
                tx_block_d = next_block;
                hold       = HOLD_ADVANCED;
              end
            end else begin
              acc_elapsed_d = '0;
              acc_prep_d    = 1'b1;
              busy_d        = 1'b1;
            end
          end
        end
      end
      MODE_FIELD: begin
        if (field_next >= field_limit) begin
          field_cnt_d = '0;
          seconds_d   = (seconds_inc >= SecondsPerDay) ? '0 : seconds_inc;
          pulse       = 1'b1;
        end else begin
          field_cnt_d = field_next[FieldW-1:0];
        end
        vbi_run_d     = 1'b1;
        vbi_elapsed_d = '0;
        acc_run_d     = 1'b1;
        acc_elapsed_d = '0;
        acc_prep_d    = 1'b0;
      end
      MODE_ACK: begin
        done_d = 1'b0;
      end
      default: begin
      end
    endcase

    result.vbi_done       = done_d;
    result.overrun        = overrun_d;
    result.window_busy    = busy_d;
    result.read_block     = tx_block_d;
    result.read_address   = addr_d;
    result.address_load   = load;
    result.mux_to_encoder = enc_sel_d;
    result.time_of_day    = seconds_d;
    result.second_pulse   = pulse;
    result.hold_reason    = hold;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vbi_ticks_q     <= VbiTicksReset;
      access_ticks_q  <= AccessTicksReset;
      prepare_ticks_q <= PrepareTicksReset;
      fields_q        <= FieldsReset;
      start_time_q    <= StartTimeReset;
      field_cnt_q     <= '0;
      seconds_q       <= StartTimeReset;
      vbi_run_q       <= 1'b0;
      vbi_elapsed_q   <= '0;
      acc_run_q       <= 1'b0;
      acc_elapsed_q   <= '0;
      acc_prep_q      <= 1'b0;
      busy_q          <= 1'b0;
      done_q          <= 1'b0;
      overrun_q       <= 1'b0;
      tx_block_q      <= '0;
      enc_sel_q       <= 1'b0;
      addr_q          <= '0;
    end else begin
      if (accept) begin
        field_cnt_q   <= field_cnt_d;
        seconds_q     <= seconds_d;
        vbi_run_q     <= vbi_run_d;
        vbi_elapsed_q <= vbi_elapsed_d;
        acc_run_q     <= acc_run_d;
        acc_elapsed_q <= acc_elapsed_d;
        acc_prep_q    <= acc_prep_d;
        busy_q        <= busy_d;
        done_q        <= done_d;
        overrun_q     <= overrun_d;
        tx_block_q    <= tx_block_d;
        enc_sel_q     <= enc_sel_d;
        addr_q        <= addr_d;
      end
      if (cfg_write) begin
        case (cfg_reg)
          REG_VBI_TICKS:     vbi_ticks_q     <= pwdata[TickW-1:0];
          REG_ACCESS_TICKS:  access_ticks_q  <= pwdata[TickW-1:0];
          REG_PREPARE_TICKS: prepare_ticks_q <= pwdata[TickW-1:0];
          REG_FIELDS:        fields_q        <= pwdata[FieldW-1:0];
          REG_START_TIME: begin
            start_time_q <= pwdata[TimeW-1:0];
            seconds_q    <= pwdata[TimeW-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Output control: result register plus one skid entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && out_stall_i) begin
      if (accept) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && out_stall_i) begin
      if (accept) begin
        skid_q <= result;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (accept) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
